/* rtl/core/tpsc_pkg.sv */
// ----------------------------------------------------------------------------
// tpsc_pkg
// Shared widths, sequencer states and inter-module structs for the
// two-prime-sum checker.
// ----------------------------------------------------------------------------
package tpsc_pkg;

  // number width (range 4..32)
  localparam int unsigned NumW   = 16;
  // tdata widths, padded to whole bytes
  localparam int unsigned InTdW  = ((NumW + 7) / 8) * 8;
  localparam int unsigned OutTdW = 8;
  // bit counter of the remainder unit, holds NumW itself
  localparam int unsigned CntW   = $clog2(NumW + 1);

  typedef logic [NumW-1:0] num_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_LOAD,
    S_TEST,
    S_WAIT,
    S_DONE
  } tpsc_state_e;

  // request to the remainder unit
  typedef struct packed {
    logic start;
    num_t dividend;
    num_t divisor;
  } tpsc_mod_req_t;

  // answer of the remainder unit
  typedef struct packed {
    logic done;
    logic rem_zero;
  } tpsc_mod_rsp_t;

  // finished answer toward the output stage
  typedef struct packed {
    logic valid;
    logic result;
  } tpsc_done_t;

endpackage

/* rtl/core/two_prime_sum_check.sv */
// ----------------------------------------------------------------------------
// two_prime_sum_check
// Tells whether a number is the sum of two primes, by trial division.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata fields (lsb first)        | tuser/tlast
//  s_axis    | in  | number_in [15:0]                | none
//  m_axis    | out | is_two_prime_sum [0], zeros     | none
//
//  Each trial division is one compare step that starts the shared remainder
//  unit, 16 shift steps, and one step that reads the remainder and bumps the
//  divisor. Each value tested adds a load step and a final compare step.
//  Candidates i run from 2 up to n/2, each costing up to about sqrt(i) +
//  sqrt(n-i) divisions.
//  Reset clears the sequencer and the output valid; payload is not reset.
//  One item at a time: s_axis_tready_o is high only while idle. A finished
//  result waits in the output register; a stalled m_axis holds the
//  sequencer at its done step but does not lose or repeat the item.
// ----------------------------------------------------------------------------
module two_prime_sum_check (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [tpsc_pkg::InTdW-1:0]  s_axis_tdata_i,  // [15:0] number_in
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [tpsc_pkg::OutTdW-1:0] m_axis_tdata_o   // [0] is_two_prime_sum
);

  tpsc_pkg::tpsc_mod_req_t mod_req;
  tpsc_pkg::tpsc_mod_rsp_t mod_rsp;
  tpsc_pkg::tpsc_done_t    done;

  logic out_valid_q, out_valid_d;
  logic out_bit_q, out_bit_d;
  logic out_free;

  // output register is free when empty or being drained this cycle
  assign out_free = !out_valid_q || m_axis_tready_i;

  tpsc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .number_i   (s_axis_tdata_i[tpsc_pkg::NumW-1:0]),
    .mod_req_o  (mod_req),
    .mod_rsp_i  (mod_rsp),
    .done_o     (done),
    .out_free_i (out_free)
  );

  // shared remainder unit: v % d, one bit per cycle
  tpsc_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_bit_d   = out_bit_q;
    if (done.valid && out_free) begin
      out_valid_d = 1'b1;
      out_bit_d   = done.result;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_bit_q <= out_bit_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(tpsc_pkg::OutTdW - 1){1'b0}}, out_bit_q};

endmodule

/* rtl/core/tpsc_mod_unit.sv */
// ----------------------------------------------------------------------------
// tpsc_mod_unit
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpsc_mod_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tpsc_pkg::tpsc_mod_req_t req_i,
  output tpsc_pkg::tpsc_mod_rsp_t rsp_o
);

  logic                      busy_q, busy_d;
  logic [tpsc_pkg::CntW-1:0] cnt_q, cnt_d;
  tpsc_pkg::num_t            rem_q, rem_d;
  tpsc_pkg::num_t            dvd_q, dvd_d;
  tpsc_pkg::num_t            dvs_q, dvs_d;
  logic [tpsc_pkg::NumW:0]   trial;

  // shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, dvd_q[tpsc_pkg::NumW-1]};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = tpsc_pkg::CntW'(tpsc_pkg::NumW);
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        dvd_d = {dvd_q[tpsc_pkg::NumW-2:0], 1'b0};
        if (trial >= {1'b0, dvs_q}) begin
          rem_d = tpsc_pkg::NumW'(trial - {1'b0, dvs_q});
        end else begin
          rem_d = trial[tpsc_pkg::NumW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = busy_q && (cnt_q == '0);
  assign rsp_o.rem_zero = (rem_q == '0);

endmodule

/* rtl/core/tpsc_seq.sv */
// ----------------------------------------------------------------------------
// tpsc_seq
// Candidate and trial-divisor sequencer around the shared remainder unit.
// ----------------------------------------------------------------------------
module tpsc_seq (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  tpsc_pkg::num_t          number_i,
  output tpsc_pkg::tpsc_mod_req_t mod_req_o,
  input  tpsc_pkg::tpsc_mod_rsp_t mod_rsp_i,
  output tpsc_pkg::tpsc_done_t    done_o,
  input  logic                    out_free_i
);

  tpsc_pkg::tpsc_state_e     state_q, state_d;
  tpsc_pkg::num_t            n_q, n_d;
  tpsc_pkg::num_t            i_q, i_d;
  tpsc_pkg::num_t            half_q, half_d;
  tpsc_pkg::num_t            v_q, v_d;
  tpsc_pkg::num_t            d_q, d_d;
  logic [tpsc_pkg::NumW:0]   dsq_q, dsq_d;   // d*d, kept by increments
  logic                      phase_q, phase_d; // 0: testing i, 1: testing n-i
  logic                      res_q, res_d;

  logic v_lt2, not_prime, is_prime, last_i, n_small;

  assign v_lt2     = (v_q < tpsc_pkg::NumW'(2));
  assign not_prime = ((state_q == tpsc_pkg::S_TEST) && v_lt2) ||
                     ((state_q == tpsc_pkg::S_WAIT) && mod_rsp_i.done &&
                      mod_rsp_i.rem_zero);
  assign is_prime  = (state_q == tpsc_pkg::S_TEST) && !v_lt2 &&
                     (dsq_q > {1'b0, v_q});
  assign last_i    = (i_q == half_q);
  assign n_small   = (n_q < tpsc_pkg::NumW'(4));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tpsc_pkg::S_IDLE:  if (in_valid_i) state_d = tpsc_pkg::S_SETUP;
      tpsc_pkg::S_SETUP: state_d = n_small ? tpsc_pkg::S_DONE : tpsc_pkg::S_LOAD;
      tpsc_pkg::S_LOAD:  state_d = tpsc_pkg::S_TEST;
      tpsc_pkg::S_TEST: begin
        if (not_prime) begin
          state_d = last_i ? tpsc_pkg::S_DONE : tpsc_pkg::S_LOAD;
        end else if (is_prime) begin
          state_d = phase_q ? tpsc_pkg::S_DONE : tpsc_pkg::S_LOAD;
        end else begin
          state_d = tpsc_pkg::S_WAIT;
        end
      end
      tpsc_pkg::S_WAIT: begin
        if (not_prime) begin
          state_d = last_i ? tpsc_pkg::S_DONE : tpsc_pkg::S_LOAD;
        end else if (mod_rsp_i.done) begin
          state_d = tpsc_pkg::S_TEST;
        end
      end
      tpsc_pkg::S_DONE:  if (out_free_i) state_d = tpsc_pkg::S_IDLE;
      default:           state_d = tpsc_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    n_d     = n_q;
    i_d     = i_q;
    half_d  = half_q;
    v_d     = v_q;
    d_d     = d_q;
    dsq_d   = dsq_q;
    phase_d = phase_q;
    res_d   = res_q;
    mod_req_o.start    = 1'b0;
    mod_req_o.dividend = v_q;
    mod_req_o.divisor  = d_q;

    unique case (state_q)
      tpsc_pkg::S_IDLE: n_d = number_i;
      tpsc_pkg::S_SETUP: begin
        res_d   = 1'b0;
        i_d     = tpsc_pkg::NumW'(2);
        half_d  = n_q >> 1;
        phase_d = 1'b0;
      end
      tpsc_pkg::S_LOAD: begin
        d_d   = tpsc_pkg::NumW'(2);
        dsq_d = (tpsc_pkg::NumW + 1)'(4);
        v_d   = phase_q ? (n_q - i_q) : i_q;
      end
      tpsc_pkg::S_TEST: begin
        if (is_prime) begin
          if (phase_q) res_d = 1'b1;
          else         phase_d = 1'b1;
        end else if (!not_prime) begin
          mod_req_o.start = 1'b1;
        end
      end
      tpsc_pkg::S_WAIT: begin
        if (mod_rsp_i.done && !mod_rsp_i.rem_zero) begin
          // (d+1)^2 = d^2 + 2d + 1
          d_d   = d_q + 1'b1;
          dsq_d = dsq_q + {d_q, 1'b1};
        end
      end
      tpsc_pkg::S_DONE: ;
      default: ;
    endcase

    // divisor found or value below 2: move to the next candidate, if any
    if (not_prime && !last_i) begin
      i_d     = i_q + 1'b1;
      phase_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpsc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    i_q     <= i_d;
    half_q  <= half_d;
    v_q     <= v_d;
    d_q     <= d_d;
    dsq_q   <= dsq_d;
    phase_q <= phase_d;
    res_q   <= res_d;
  end

  assign in_ready_o    = (state_q == tpsc_pkg::S_IDLE);
  assign done_o.valid  = (state_q == tpsc_pkg::S_DONE);
  assign done_o.result = res_q;

endmodule

/* rtl/core/tpsc_checker.sv */
// ----------------------------------------------------------------------------
// tpsc_checker
// Port-level checks for two_prime_sum_check, bound to the top level.
// ----------------------------------------------------------------------------
module tpsc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid_i,
  input logic                        s_axis_tready_o,
  input logic [tpsc_pkg::InTdW-1:0]  s_axis_tdata_i,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [tpsc_pkg::OutTdW-1:0] m_axis_tdata_o
);

  // no result shown in the cycle after reset is sampled active
  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // an accepted item keeps the input closed for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready right after accept");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // padding bits above the flag stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[tpsc_pkg::OutTdW-1:1] == '0)
    else $error("nonzero padding in result");

endmodule

bind two_prime_sum_check tpsc_checker u_tpsc_checker (.*);
